### rtl/core/baro_temp_pressure_compensation_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// These macros wrap the concurrent assertions used at the top level.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_MACROS_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/btpc_pkg.sv
// ----------------------------------------------------------------------------
// Barometric compensation package
// Types, trim layout and constants shared by the compensation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package btpc_pkg;

	localparam int DivBits   = 64;
	localparam int DenomBits = 31;

	localparam logic signed [24:0] FineOffset = 25'sd128000;
	localparam logic [20:0]        PressBase  = 21'd1048576;
	localparam logic [11:0]        PressScale = 12'd3125;
	localparam logic [63:0]        Bias47     = 64'h0000_8000_0000_0000;

	typedef enum logic [1:0] {
		REG_TEMP_TRIM,
		REG_PRESS_TRIM_LOW,
		REG_PRESS_TRIM_HIGH,
		REG_PRESS_TRIM_NINE
	} cfg_reg_t;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] fine_temperature;
		logic signed [23:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic               pressure_valid;
	} result_t;

	typedef struct packed {
		logic [15:0]        t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic [15:0]        p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} trim_t;

	typedef struct packed {
		logic signed [31:0] fine_temperature;
		logic signed [23:0] temperature_centi;
	} temp_out_t;

	typedef struct packed {
		temp_out_t   temp;
		logic [19:0] raw_pressure;
	} temp_res_t;

	typedef struct packed {
		temp_out_t            temp;
		logic [63:0]          numer;
		logic [DenomBits-1:0] denom;
	} coef_res_t;

	typedef struct packed {
		temp_out_t temp;
		logic      div_zero;
	} div_side_t;

	typedef struct packed {
		logic [DenomBits-1:0] rem;
		logic [DivBits-1:0]   nq;
		logic [DenomBits-1:0] md;
		logic                 neg;
		div_side_t            side;
	} div_step_t;

	typedef struct packed {
		div_side_t          side;
		logic [DivBits-1:0] quot;
	} div_res_t;

endpackage

`default_nettype wire

### rtl/core/btpc_if.sv
// ----------------------------------------------------------------------------
// Barometric compensation channels
// Valid/ready channels for raw samples and compensated results.
// ----------------------------------------------------------------------------
`default_nettype none

interface btpc_in_if;
	import btpc_pkg::*;
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface btpc_out_if;
	import btpc_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/btpc_temp.sv
// ----------------------------------------------------------------------------
// Temperature compensation pipeline
// Five stages from the raw temperature to the fine and centidegree values.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_temp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  btpc_pkg::sample_t   in_data,
	input  btpc_pkg::trim_t     trim,
	output logic                out_valid,
	output btpc_pkg::temp_res_t out_data
);
	import btpc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic signed [17:0] dx_s1;
	logic signed [16:0] dd_s1;
	logic [19:0]        rp_s1, rp_s2, rp_s3, rp_s4, rp_s5;
	logic signed [33:0] am_s2;
	logic [31:0]        sq_s2;
	logic signed [22:0] a_s3;
	logic signed [36:0] bm_s3;
	logic signed [23:0] tf_s4;
	logic signed [31:0] fine_s5;
	logic signed [23:0] centi_s5;

	logic signed [33:0] sq_full;
	logic signed [26:0] t27;
	logic signed [26:0] t5;

	assign sq_full = dd_s1 * dd_s1;
	assign t27     = {{3{tf_s4[23]}}, tf_s4};
	assign t5      = (t27 <<< 2) + t27 + 27'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1    <= $signed({1'b0, in_data.raw_temperature[19:3]})
				- $signed({1'b0, trim.t1, 1'b0});
			dd_s1    <= $signed({1'b0, in_data.raw_temperature[19:4]})
				- $signed({1'b0, trim.t1});
			rp_s1    <= in_data.raw_pressure;
			am_s2    <= dx_s1 * $signed(trim.t2);
			sq_s2    <= sq_full[31:0];
			rp_s2    <= rp_s1;
			a_s3     <= $signed(am_s2[33:11]);
			bm_s3    <= $signed({1'b0, sq_s2[31:12]}) * $signed(trim.t3);
			rp_s3    <= rp_s2;
			tf_s4    <= a_s3 + $signed(bm_s3[36:14]);
			rp_s4    <= rp_s3;
			fine_s5  <= {{8{tf_s4[23]}}, tf_s4};
			centi_s5 <= $signed({{5{t5[26]}}, t5[26:8]});
			rp_s5    <= rp_s4;
		end
	end

	assign out_valid                      = valid_s5;
	assign out_data.temp.fine_temperature  = fine_s5;
	assign out_data.temp.temperature_centi = centi_s5;
	assign out_data.raw_pressure           = rp_s5;

endmodule

`default_nettype wire

### rtl/core/btpc_coef.sv
// ----------------------------------------------------------------------------
// Pressure coefficient pipeline
// Six stages that form the 64-bit dividend and the divisor of the pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_coef (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  btpc_pkg::temp_res_t in_data,
	input  btpc_pkg::trim_t     trim,
	output logic                out_valid,
	output btpc_pkg::coef_res_t out_data
);
	import btpc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	temp_out_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6;
	logic signed [24:0] v1_s1;
	logic [20:0]        prs_s1, prs_s2, prs_s3, prs_s4;
	logic signed [49:0] sq_s2;
	logic signed [40:0] m5_s2, m2_s2, m5_s3, m2_s3;
	logic [63:0]        x6_s3, x3_s3;
	logic [63:0]        v2_s4, w_s4;
	logic [63:0]        y_s5, nd_s5;
	logic [63:0]        numer_s6;
	logic [DenomBits-1:0] denom_s6;

	logic signed [65:0] x6_full, x3_full;
	logic [79:0]        y_full;
	logic [75:0]        n_full;

	assign x6_full = sq_s2 * $signed(trim.p6);
	assign x3_full = sq_s2 * $signed(trim.p3);
	assign y_full  = w_s4 * trim.p1;
	assign n_full  = nd_s5 * PressScale;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v1_s1    <= $signed(in_data.temp.fine_temperature[24:0]) - FineOffset;
			prs_s1   <= PressBase - {1'b0, in_data.raw_pressure};
			side_s1  <= in_data.temp;
			sq_s2    <= v1_s1 * v1_s1;
			m5_s2    <= v1_s1 * $signed(trim.p5);
			m2_s2    <= v1_s1 * $signed(trim.p2);
			prs_s2   <= prs_s1;
			side_s2  <= side_s1;
			x6_s3    <= x6_full[63:0];
			x3_s3    <= x3_full[63:0];
			m5_s3    <= m5_s2;
			m2_s3    <= m2_s2;
			prs_s3   <= prs_s2;
			side_s3  <= side_s2;
			v2_s4    <= x6_s3 + {{6{m5_s3[40]}}, m5_s3, 17'b0}
				+ {{13{trim.p4[15]}}, trim.p4, 35'b0};
			w_s4     <= {{8{x3_s3[63]}}, x3_s3[63:8]} + {{11{m2_s3[40]}}, m2_s3, 12'b0}
				+ Bias47;
			prs_s4   <= prs_s3;
			side_s4  <= side_s3;
			y_s5     <= y_full[63:0];
			nd_s5    <= {12'b0, prs_s4, 31'b0} - v2_s4;
			side_s5  <= side_s4;
			numer_s6 <= n_full[63:0];
			denom_s6 <= y_s5[63:64-DenomBits];
			side_s6  <= side_s5;
		end
	end

	assign out_valid      = valid_s6;
	assign out_data.temp  = side_s6;
	assign out_data.numer = numer_s6;
	assign out_data.denom = denom_s6;

endmodule

`default_nettype wire

### rtl/core/btpc_div.sv
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division with one quotient bit per stage and truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  btpc_pkg::coef_res_t in_data,
	output logic                out_valid,
	output btpc_pkg::div_res_t  out_data
);
	import btpc_pkg::*;

	div_step_t          step_s [0:DivBits];
	logic [DivBits:0]   vld_s;
	logic               valid_s65;
	div_side_t          side_s65;
	logic [DivBits-1:0] quot_s65;

	logic [DivBits-1:0]   mag_n;
	logic [DenomBits-1:0] mag_d;

	assign mag_n = in_data.numer[DivBits-1] ? ({DivBits{1'b0}} - in_data.numer) : in_data.numer;
	assign mag_d = in_data.denom[DenomBits-1] ? ({DenomBits{1'b0}} - in_data.denom)
		: in_data.denom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			valid_s65 <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[DivBits-1:0], in_valid};
			valid_s65 <= vld_s[DivBits];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			step_s[0].rem            <= '0;
			step_s[0].nq             <= mag_n;
			step_s[0].md             <= mag_d;
			step_s[0].neg            <= in_data.numer[DivBits-1] ^ in_data.denom[DenomBits-1];
			step_s[0].side.temp      <= in_data.temp;
			step_s[0].side.div_zero  <= (in_data.denom == '0);
		end
	end

	for (genvar k = 0; k < DivBits; k++) begin : g_step
		logic [DenomBits:0] trial;
		logic [DenomBits:0] diff;
		logic               ge;

		assign trial = {step_s[k].rem, step_s[k].nq[DivBits-1]};
		assign ge    = trial >= {1'b0, step_s[k].md};
		assign diff  = trial - {1'b0, step_s[k].md};

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[k+1].rem  <= ge ? diff[DenomBits-1:0] : trial[DenomBits-1:0];
				step_s[k+1].nq   <= {step_s[k].nq[DivBits-2:0], ge};
				step_s[k+1].md   <= step_s[k].md;
				step_s[k+1].neg  <= step_s[k].neg;
				step_s[k+1].side <= step_s[k].side;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s65 <= step_s[DivBits].neg ? ({DivBits{1'b0}} - step_s[DivBits].nq)
				: step_s[DivBits].nq;
			side_s65 <= step_s[DivBits].side;
		end
	end

	assign out_valid     = valid_s65;
	assign out_data.side = side_s65;
	assign out_data.quot = quot_s65;

endmodule

`default_nettype wire

### rtl/core/btpc_post.sv
// ----------------------------------------------------------------------------
// Pressure correction pipeline
// Six stages of second-order correction, offset and saturation to Q24.8.
// ----------------------------------------------------------------------------
`default_nettype none

module btpc_post (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  btpc_pkg::div_res_t in_data,
	input  btpc_pkg::trim_t    trim,
	output logic               out_valid,
	output btpc_pkg::result_t  out_data
);
	import btpc_pkg::*;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	div_side_t side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [63:0] quot_s1, quot_s2, quot_s3;
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [63:0] bb_s1;
	logic [63:0] sq_s2, b_s2, b_s3;
	logic [63:0] am_s3;
	logic [63:0] sum_s4;
	logic [63:0] r_s5;
	result_t     res_s6;

	logic [63:0]        s13;
	logic [63:0]        ll_full, lh_full;
	logic signed [79:0] bb_full, am_full;

	assign s13     = {{13{in_data.quot[63]}}, in_data.quot[63:13]};
	assign ll_full = s13[31:0] * s13[31:0];
	assign lh_full = s13[31:0] * s13[63:32];
	assign bb_full = $signed(in_data.quot) * $signed(trim.p8);
	assign am_full = $signed(sq_s2) * $signed(trim.p9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1   <= ll_full;
			lh_s1   <= lh_full[31:0];
			bb_s1   <= bb_full[63:0];
			quot_s1 <= in_data.quot;
			side_s1 <= in_data.side;
			sq_s2   <= ll_s1 + {lh_s1[30:0], 33'b0};
			b_s2    <= {{19{bb_s1[63]}}, bb_s1[63:19]};
			quot_s2 <= quot_s1;
			side_s2 <= side_s1;
			am_s3   <= am_full[63:0];
			b_s3    <= b_s2;
			quot_s3 <= quot_s2;
			side_s3 <= side_s2;
			sum_s4  <= quot_s3 + {{25{am_s3[63]}}, am_s3[63:25]} + b_s3;
			side_s4 <= side_s3;
			r_s5    <= {{8{sum_s4[63]}}, sum_s4[63:8]} + {{44{trim.p7[15]}}, trim.p7, 4'b0};
			side_s5 <= side_s4;
			res_s6.fine_temperature  <= side_s5.temp.fine_temperature;
			res_s6.temperature_centi <= side_s5.temp.temperature_centi;
			res_s6.pressure_valid    <= !side_s5.div_zero;
			if (side_s5.div_zero || r_s5[63]) begin
				res_s6.pressure_q24_8 <= '0;
			end else if (|r_s5[62:32]) begin
				res_s6.pressure_q24_8 <= '1;
			end else begin
				res_s6.pressure_q24_8 <= r_s5[31:0];
			end
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = res_s6;

endmodule

`default_nettype wire

### rtl/core/baro_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric temperature and pressure compensation
// Turns one raw 20-bit temperature and pressure pair into the fine temperature,
// the temperature in hundredths of a degree and the pressure in pascal as
// unsigned Q24.8, using the twelve factory trim words held in the configuration
// registers. The block takes one sample per cycle while the output is not stalled.
// Its pipeline has 5 stages of temperature math, 6 stages that build the dividend
// and divisor, 66 stages of the signed divider, 64 of which retire one quotient
// bit each, and 6 stages of pressure correction ending in the output register.
// When the output register holds a result that is not taken, the whole pipeline
// holds and the sample input is not ready. A zero divisor gives a pressure of
// zero with the pressure valid flag low.
// ----------------------------------------------------------------------------
`default_nettype none
`include "baro_temp_pressure_compensation_top_macros.svh"

module baro_temp_pressure_compensation_top (
	input  logic        clk,
	input  logic        arst_n,
	btpc_in_if.sink     samples,
	btpc_out_if.source  results,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_wdata
);
	import btpc_pkg::*;

	logic [47:0] temp_trim_q;
	logic [63:0] press_trim_low_q;
	logic [63:0] press_trim_high_q;
	logic [15:0] press_trim_nine_q;

	trim_t     trim;
	logic      pipe_en;
	logic      temp_valid, coef_valid, div_valid, post_valid;
	temp_res_t temp_data;
	coef_res_t coef_data;
	div_res_t  div_data;
	result_t   post_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q       <= '0;
			press_trim_low_q  <= '0;
			press_trim_high_q <= '0;
			press_trim_nine_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TEMP_TRIM:       temp_trim_q       <= cfg_wdata[47:0];
				REG_PRESS_TRIM_LOW:  press_trim_low_q  <= cfg_wdata;
				REG_PRESS_TRIM_HIGH: press_trim_high_q <= cfg_wdata;
				REG_PRESS_TRIM_NINE: press_trim_nine_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		trim.t1 = temp_trim_q[15:0];
		trim.t2 = temp_trim_q[31:16];
		trim.t3 = temp_trim_q[47:32];
		trim.p1 = press_trim_low_q[15:0];
		trim.p2 = press_trim_low_q[31:16];
		trim.p3 = press_trim_low_q[47:32];
		trim.p4 = press_trim_low_q[63:48];
		trim.p5 = press_trim_high_q[15:0];
		trim.p6 = press_trim_high_q[31:16];
		trim.p7 = press_trim_high_q[47:32];
		trim.p8 = press_trim_high_q[63:48];
		trim.p9 = press_trim_nine_q;
	end

	// The pipeline advances whenever the output register is empty or its
	// result is transferred in this cycle.
	assign pipe_en       = !post_valid || results.ready;
	assign samples.ready = pipe_en;
	assign results.valid = post_valid;
	assign results.data  = post_data;

	btpc_temp u_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (samples.valid),
		.in_data   (samples.data),
		.trim      (trim),
		.out_valid (temp_valid),
		.out_data  (temp_data)
	);

	btpc_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (temp_valid),
		.in_data   (temp_data),
		.trim      (trim),
		.out_valid (coef_valid),
		.out_data  (coef_data)
	);

	btpc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (coef_valid),
		.in_data   (coef_data),
		.out_valid (div_valid),
		.out_data  (div_data)
	);

	btpc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.in_valid  (div_valid),
		.in_data   (div_data),
		.trim      (trim),
		.out_valid (post_valid),
		.out_data  (post_data)
	);

	`BTPC_ASSERT_SAME(a_invalid_zero, results.valid && !results.data.pressure_valid, results.data.pressure_q24_8 == 32'd0, "pressure not zero on zero divisor")
	`BTPC_ASSERT_SAME(a_stall_input, results.valid && !results.ready, !samples.ready, "input ready while output stalled")
	`BTPC_ASSERT_NEXT(a_stall_holds, !samples.ready, results.valid, "output lost during stall")

endmodule

`default_nettype wire

### tb/tb_baro_temp_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// Testbench for the barometric temperature and pressure compensation block
// Drives raw temperature and pressure samples under several trim settings,
// predicts each result with integer compensation math, and compares every
// result transfer field by field, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_baro_temp_pressure_compensation_top;
	import btpc_pkg::*;

	localparam int CycleLimit = 1000000;
	localparam int DrainCycles = 100;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_wdata;

	btpc_in_if  sample_ch ();
	btpc_out_if result_ch ();

	baro_temp_pressure_compensation_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	logic [47:0] temp_trim_q;
	logic [63:0] press_low_q;
	logic [63:0] press_high_q;
	logic [15:0] press_nine_q;

	result_t expected_results[$];
	int      error_count;
	int      cycle_count;
	bit      sender_quiet;
	bit      receiver_quiet;
	bit      hold_request;
	int      hold_left;
	int      stall_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint sx16(logic [15:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint div_trunc(longint n, longint d);
		logic [63:0] mn;
		logic [63:0] md;
		logic [63:0] q;
		mn = (n < 0) ? -n : n;
		md = (d < 0) ? -d : d;
		q = mn / md;
		if ((n < 0) != (d < 0))
			q = -q;
		return longint'(q);
	endfunction

	function automatic result_t compensate(sample_t s);
		longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
		longint at, ap, a, b, d, tf, tc, v1, v2, p;
		result_t r;
		t1 = longint'({48'b0, temp_trim_q[15:0]});
		t2 = sx16(temp_trim_q[31:16]);
		t3 = sx16(temp_trim_q[47:32]);
		p1 = longint'({48'b0, press_low_q[15:0]});
		p2 = sx16(press_low_q[31:16]);
		p3 = sx16(press_low_q[47:32]);
		p4 = sx16(press_low_q[63:48]);
		p5 = sx16(press_high_q[15:0]);
		p6 = sx16(press_high_q[31:16]);
		p7 = sx16(press_high_q[47:32]);
		p8 = sx16(press_high_q[63:48]);
		p9 = sx16(press_nine_q);
		at = longint'({44'b0, s.raw_temperature});
		ap = longint'({44'b0, s.raw_pressure});

		a = (((at >>> 3) - (t1 <<< 1)) * t2) >>> 11;
		d = (at >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		tf = a + b;
		tc = (tf * 5 + 128) >>> 8;
		if (tc < -64'sd8388608)
			tc = -64'sd8388608;
		else if (tc > 64'sd8388607)
			tc = 64'sd8388607;
		r.fine_temperature = tf[31:0];
		r.temperature_centi = tc[23:0];

		v1 = tf - 64'sd128000;
		v2 = v1 * v1 * p6;
		v2 = v2 + ((v1 * p5) <<< 17);
		v2 = v2 + (p4 <<< 35);
		v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
		if (v1 == 0) begin
			r.pressure_valid = 1'b0;
			r.pressure_q24_8 = '0;
		end else begin
			r.pressure_valid = 1'b1;
			p = 64'sd1048576 - ap;
			p = div_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
			a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
			b = (p8 * p) >>> 19;
			p = ((p + a + b) >>> 8) + (p7 <<< 4);
			if (p < 0)
				r.pressure_q24_8 = '0;
			else if (p > 64'sh0000_0000_FFFF_FFFF)
				r.pressure_q24_8 = 32'hFFFF_FFFF;
			else
				r.pressure_q24_8 = p[31:0];
		end
		return r;
	endfunction

	task automatic write_trim(cfg_reg_t idx, logic [63:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TEMP_TRIM: begin
				temp_trim_q = value[47:0];
			end
			REG_PRESS_TRIM_LOW: begin
				press_low_q = value;
			end
			REG_PRESS_TRIM_HIGH: begin
				press_high_q = value;
			end
			default: begin
				press_nine_q = value[15:0];
			end
		endcase
		@(posedge clk);
	endtask

	task automatic load_trims(logic [47:0] tt, logic [63:0] pl, logic [63:0] ph,
			logic [15:0] p9);
		write_trim(REG_TEMP_TRIM, {16'b0, tt});
		write_trim(REG_PRESS_TRIM_LOW, pl);
		write_trim(REG_PRESS_TRIM_HIGH, ph);
		write_trim(REG_PRESS_TRIM_NINE, {48'b0, p9});
	endtask

	task automatic load_typical();
		load_trims({16'hFC18, 16'd26435, 16'd27504},
			{16'd2855, 16'd3024, 16'hD643, 16'd36477},
			{16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
	endtask

	task automatic send_sample(sample_t s);
		int gap;
		gap = 0;
		if (!sender_quiet && $urandom_range(0, 99) < 30)
			gap = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		expected_results.push_back(compensate(s));
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	function automatic sample_t random_sample();
		sample_t s;
		s.raw_temperature = 20'($urandom_range(0, 20'hFFFFF));
		s.raw_pressure = 20'($urandom_range(0, 20'hFFFFF));
		if ($urandom_range(0, 1)) begin
			s.raw_temperature = 20'($urandom_range(400000, 600000));
			s.raw_pressure = 20'($urandom_range(250000, 500000));
		end
		return s;
	endfunction

	task automatic test_reset_trims();
		send_sample('{raw_temperature: 20'h00000, raw_pressure: 20'h00000});
		send_sample('{raw_temperature: 20'hFFFFF, raw_pressure: 20'hFFFFF});
		send_sample('{raw_temperature: 20'h80000, raw_pressure: 20'h7FFFF});
		drain();
	endtask

	task automatic test_typical_trims();
		load_typical();
		send_sample('{raw_temperature: 20'd519888, raw_pressure: 20'd415148});
		send_sample('{raw_temperature: 20'h00000, raw_pressure: 20'h00000});
		send_sample('{raw_temperature: 20'hFFFFF, raw_pressure: 20'hFFFFF});
		send_sample('{raw_temperature: 20'h00000, raw_pressure: 20'hFFFFF});
		send_sample('{raw_temperature: 20'hFFFFF, raw_pressure: 20'h00000});
		send_sample('{raw_temperature: 20'h55555, raw_pressure: 20'hAAAAA});
		send_sample('{raw_temperature: 20'hAAAAA, raw_pressure: 20'h55555});
		drain();
	endtask

	task automatic test_pressure_limits();
		// A tiny divisor drives the pressure above the top of its range.
		write_trim(REG_PRESS_TRIM_LOW, {16'd2855, 16'd3024, 16'hD643, 16'd1});
		send_sample('{raw_temperature: 20'd519888, raw_pressure: 20'd0});
		send_sample('{raw_temperature: 20'd519888, raw_pressure: 20'd415148});
		drain();
		// A large negative offset with almost no pressure goes below zero.
		load_typical();
		write_trim(REG_PRESS_TRIM_HIGH, {16'h8000, 16'h8000, 16'hFFF9, 16'd140});
		send_sample('{raw_temperature: 20'd519888, raw_pressure: 20'hFFFFF});
		send_sample('{raw_temperature: 20'd519888, raw_pressure: 20'hFFFF0});
		drain();
	endtask

	task automatic test_trim_extremes();
		load_trims(48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
		send_sample('{raw_temperature: 20'h00000, raw_pressure: 20'h00000});
		send_sample('{raw_temperature: 20'hFFFFF, raw_pressure: 20'hFFFFF});
		drain();
		load_trims(48'h8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
			64'h8000_8000_8000_8000, 16'h8000);
		send_sample('{raw_temperature: 20'h00000, raw_pressure: 20'hFFFFF});
		send_sample('{raw_temperature: 20'hFFFFF, raw_pressure: 20'h00000});
		drain();
		load_trims(48'h7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001,
			64'h7FFF_7FFF_7FFF_7FFF, 16'h7FFF);
		send_sample('{raw_temperature: 20'hFFFFF, raw_pressure: 20'hFFFFF});
		send_sample('{raw_temperature: 20'h00000, raw_pressure: 20'h00000});
		drain();
	endtask

	task automatic test_backpressure();
		load_typical();
		sender_quiet = 1'b1;
		hold_request = 1'b1;
		repeat (150) send_sample(random_sample());
		sender_quiet = 1'b0;
		drain();
	endtask

	task automatic test_random_trims();
		for (int phase = 0; phase < 8; phase++) begin
			if (phase % 2 == 0) begin
				load_typical();
				write_trim(REG_TEMP_TRIM, {16'b0, 16'($urandom_range(0, 16'hFFFF)),
					16'($urandom_range(20000, 30000)),
					16'($urandom_range(25000, 35000))});
			end else begin
				load_trims(48'({$urandom(), $urandom()}), {$urandom(), $urandom()},
					{$urandom(), $urandom()}, 16'($urandom()));
			end
			sender_quiet = (phase == 3);
			receiver_quiet = (phase == 5);
			repeat (80) send_sample(random_sample());
			sender_quiet = 1'b0;
			receiver_quiet = 1'b0;
			drain();
		end
	endtask

	always @(posedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = 300;
		end
		if (hold_left > 0) begin
			result_ch.ready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			result_ch.ready <= 1'b0;
			stall_left--;
		end else if (receiver_quiet || $urandom_range(0, 99) < 70) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= 1'b0;
			stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no result expected");
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (result_ch.data.fine_temperature !== want.fine_temperature) begin
					$error("fine_temperature expected %0d actual %0d",
						want.fine_temperature, result_ch.data.fine_temperature);
					error_count++;
				end
				if (result_ch.data.temperature_centi !== want.temperature_centi) begin
					$error("temperature_centi expected %0d actual %0d",
						want.temperature_centi, result_ch.data.temperature_centi);
					error_count++;
				end
				if (result_ch.data.pressure_q24_8 !== want.pressure_q24_8) begin
					$error("pressure_q24_8 expected %0d actual %0d",
						want.pressure_q24_8, result_ch.data.pressure_q24_8);
					error_count++;
				end
				if (result_ch.data.pressure_valid !== want.pressure_valid) begin
					$error("pressure_valid expected %0d actual %0d",
						want.pressure_valid, result_ch.data.pressure_valid);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TEMP_TRIM;
		cfg_wdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		temp_trim_q = '0;
		press_low_q = '0;
		press_high_q = '0;
		press_nine_q = '0;
		error_count = 0;
		cycle_count = 0;
		sender_quiet = 1'b0;
		receiver_quiet = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		stall_left = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_trims();
		test_typical_trims();
		test_pressure_limits();
		test_trim_extremes();
		test_backpressure();
		test_random_trims();
		drain();

		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
